// ===== hw/rtl/slt_pkg.sv =====
// ---------------------------------------------------------------------------
// slt_pkg: shared definitions for the sorted list table
// Operation and status codes, default sizes and the control and tap bundles
// passed between the top level and the row of storage cells.
// ---------------------------------------------------------------------------
package slt_pkg;

	// Default sizes for the top-level parameters.
	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 16;

	// Operation codes carried in the func field.
	typedef enum logic [2:0] {
		FN_INSERT = 3'd0,
		FN_DELETE = 3'd1,
		FN_LOOKUP = 3'd2,
		FN_REWIND = 3'd3,
		FN_READ   = 3'd4
	} func_t;

	// Status codes returned with every result beat.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_END       = 2'd3
	} status_t;

	// Per-cycle command broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctrl_t;

	// Flags a cell reports when it sits at the read cursor.
	typedef struct packed {
		logic lt_at_cur;
		logic eq_before_cur;
	} cell_tap_t;

endpackage

// ===== hw/rtl/slt_cell.sv =====
// ---------------------------------------------------------------------------
// slt_cell: one slot of the sorted list table
// Holds one entry, compares it with the broadcast value and shifts toward
// its left or right neighbor on insert and delete.
// ---------------------------------------------------------------------------
module slt_cell #(
	parameter int DATA_WIDTH = slt_pkg::DATA_WIDTH_DEF,
	parameter int CNT_WIDTH  = 5,
	parameter int IDX        = 0
) (
	input  logic                    clk,
	input  slt_pkg::cell_ctrl_t     ctrl,
	input  logic [DATA_WIDTH-1:0]   value,
	input  logic [CNT_WIDTH-1:0]    count,
	input  logic [CNT_WIDTH-1:0]    cur,
	input  logic [DATA_WIDTH-1:0]   left_entry,
	input  logic [DATA_WIDTH-1:0]   right_entry,
	input  logic                    left_lt,
	input  logic                    left_seen,
	output logic [DATA_WIDTH-1:0]   entry,
	output logic                    lt,
	output logic                    seen,
	output slt_pkg::cell_tap_t      tap,
	output logic [DATA_WIDTH-1:0]   tap_item
);

	logic [DATA_WIDTH-1:0] entry_q;
	logic                  occupied;
	logic                  eq;
	logic                  at_cur;

	// Compare the stored entry against the broadcast value.
	assign occupied = CNT_WIDTH'(IDX) < count;
	assign lt       = occupied && (entry_q < value);
	assign eq       = occupied && (entry_q == value);
	assign seen     = left_seen | eq;
	assign entry    = entry_q;

	// Report flags and the entry when this slot is under the read cursor.
	assign at_cur            = (cur == CNT_WIDTH'(IDX));
	assign tap.lt_at_cur     = at_cur & lt;
	assign tap.eq_before_cur = at_cur & left_seen;
	assign tap_item          = at_cur ? entry_q : '0;

	// Insert opens a gap at the first slot not below the value; delete closes
	// the gap left by the first equal entry.
	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt) begin
			entry_q <= left_lt ? value : left_entry;
		end else if (ctrl.del && seen) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== hw/rtl/sorted_list_table.sv =====
// ---------------------------------------------------------------------------
// sorted_list_table: ascending sorted table with insert, delete and cursor
// A row of compare-and-shift cells keeps the entries in order; a small
// control section tracks the count and the read cursor.
// ---------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ----------------------------------------
//  in       in_valid / in_ready  func, value
//  out      out_valid/out_ready  status, found, item_out, entry_count,
//                                is_empty, more_to_read
//
// All cells compare at once and shift at the accepting edge, and the result
// beat appears on the next cycle.
// A new beat is accepted each cycle while the result side keeps taking them;
// when the result register holds an untaken beat, in_ready follows out_ready.
// Reset clears the count and the cursor; entry storage is not reset.
// The longest path is the ripple of the compare flags along the cell row.
// ---------------------------------------------------------------------------
module sorted_list_table #(
	parameter int CAPACITY   = slt_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = slt_pkg::DATA_WIDTH_DEF,
	localparam int CW        = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            func,
	input  logic [DATA_WIDTH-1:0] value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic                  found,
	output logic [DATA_WIDTH-1:0] item_out,
	output logic [CW-1:0]         entry_count,
	output logic                  is_empty,
	output logic                  more_to_read
);

	logic [CW-1:0] count_q;
	logic [CW-1:0] rc_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] rc_d;
	logic [CW-1:0] cur;
	logic          out_valid_q;
	logic          accept;
	logic          full;

	slt_pkg::status_t      status_d;
	slt_pkg::status_t      status_q;
	logic                  found_d;
	logic                  found_q;
	logic [DATA_WIDTH-1:0] item_d;
	logic [DATA_WIDTH-1:0] item_q;

	slt_pkg::cell_ctrl_t   ctrl;
	logic [DATA_WIDTH-1:0] entry_w [CAPACITY];
	logic                  lt_w    [CAPACITY];
	logic                  seen_w  [CAPACITY];
	slt_pkg::cell_tap_t    tap_w   [CAPACITY];
	logic [DATA_WIDTH-1:0] item_w  [CAPACITY];
	logic                  sel_lt;
	logic                  sel_seen;
	logic [DATA_WIDTH-1:0] sel_item;

	// Handshake: accept whenever the result register is free or draining.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CW'(CAPACITY));
	assign cur      = count_q - rc_q;

	// Command broadcast to the cell row.
	assign ctrl.ins = accept && (func == slt_pkg::FN_INSERT) && !full;
	assign ctrl.del = accept && (func == slt_pkg::FN_DELETE);

	// Row of storage cells.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		slt_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.CNT_WIDTH (CW),
			.IDX       (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.value      (value),
			.count      (count_q),
			.cur        (cur),
			.left_entry ((i == 0) ? value : entry_w[(i == 0) ? 0 : i - 1]),
			.right_entry((i == CAPACITY - 1) ? entry_w[i]
				: entry_w[(i == CAPACITY - 1) ? i : i + 1]),
			.left_lt    ((i == 0) ? 1'b1 : lt_w[(i == 0) ? 0 : i - 1]),
			.left_seen  ((i == 0) ? 1'b0 : seen_w[(i == 0) ? 0 : i - 1]),
			.entry      (entry_w[i]),
			.lt         (lt_w[i]),
			.seen       (seen_w[i]),
			.tap        (tap_w[i]),
			.tap_item   (item_w[i])
		);
	end

	// Gather the cursor taps; at most one cell is selected.
	always_comb begin
		sel_lt   = 1'b0;
		sel_seen = 1'b0;
		sel_item = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			sel_lt   = sel_lt | tap_w[i].lt_at_cur;
			sel_seen = sel_seen | tap_w[i].eq_before_cur;
			sel_item = sel_item | item_w[i];
		end
	end

	// Next count, cursor and result for the offered operation.
	always_comb begin
		count_d  = count_q;
		rc_d     = rc_q;
		status_d = slt_pkg::ST_OK;
		found_d  = 1'b0;
		item_d   = '0;
		case (slt_pkg::func_t'(func))
			slt_pkg::FN_INSERT: begin
				if (full) begin
					status_d = slt_pkg::ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
					if (rc_q != '0 && sel_lt) begin
						rc_d = rc_q + CW'(1);
					end
				end
			end
			slt_pkg::FN_DELETE: begin
				if (seen_w[CAPACITY-1]) begin
					found_d = 1'b1;
					count_d = count_q - CW'(1);
					if (rc_q != '0 && !sel_seen) begin
						rc_d = rc_q - CW'(1);
					end
				end else begin
					status_d = slt_pkg::ST_NOT_FOUND;
				end
			end
			slt_pkg::FN_LOOKUP: begin
				found_d = seen_w[CAPACITY-1];
			end
			slt_pkg::FN_REWIND: begin
				rc_d = count_q;
			end
			slt_pkg::FN_READ: begin
				if (rc_q == '0) begin
					status_d = slt_pkg::ST_END;
				end else begin
					item_d = sel_item;
					rc_d   = rc_q - CW'(1);
				end
			end
			default: begin
				status_d = slt_pkg::ST_OK;
			end
		endcase
	end

	// Control state: count, cursor and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rc_q        <= rc_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			found_q  <= found_d;
			item_q   <= item_d;
		end
	end

	// The count and cursor registers always reflect the last accepted beat.
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found        = found_q;
	assign item_out     = item_q;
	assign entry_count  = count_q;
	assign is_empty     = (count_q == '0);
	assign more_to_read = (rc_q != '0);

endmodule

// ===== verif/sorted_list_table_chk.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_list_table_chk: result checker for the sorted list table
// Watches the input and result channels, keeps a behavioral copy of the
// table, its count and its read cursor, and compares each accepted result
// beat, field by field, with the prediction for the oldest input beat.
// ---------------------------------------------------------------------------
module sorted_list_table_chk #(
	parameter int CAPACITY   = slt_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = slt_pkg::DATA_WIDTH_DEF,
	parameter int CW         = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [2:0]            func,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [1:0]            status,
	input  logic                  found,
	input  logic [DATA_WIDTH-1:0] item_out,
	input  logic [CW-1:0]         entry_count,
	input  logic                  is_empty,
	input  logic                  more_to_read,
	output int                    fail_cnt,
	output int                    pending_cnt
);
	import slt_pkg::*;

	typedef struct packed {
		status_t               status;
		logic                  found;
		logic [DATA_WIDTH-1:0] item;
		logic [CW-1:0]         count;
		logic                  empty;
		logic                  more;
	} table_result_t;

	// Shadow table: sorted entries, number stored, entries still ahead of the cursor.
	logic [DATA_WIDTH-1:0] shadow_row [CAPACITY];
	int                    shadow_count;
	int                    shadow_ahead;
	table_result_t         expected_results [$];

	// Applies one operation to the shadow table and returns the result it gives.
	function automatic table_result_t apply_table_op(input logic [2:0] op,
			input logic [DATA_WIDTH-1:0] v);
		table_result_t res;
		int            cur;
		int            pos;
		int            i;
		res = '0;
		res.status = ST_OK;
		cur = shadow_count - shadow_ahead;
		case (op)
			FN_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < shadow_count && shadow_row[pos] < v)
						pos++;
					for (i = shadow_count; i > pos; i--)
						shadow_row[i] = shadow_row[i-1];
					shadow_row[pos] = v;
					// Only an entry landing after the cursor adds to what is left to read.
					if (shadow_ahead != 0 && pos > cur)
						shadow_ahead++;
					shadow_count++;
				end
			end
			FN_DELETE: begin
				pos = -1;
				for (i = 0; i < shadow_count; i++) begin
					if (pos < 0 && shadow_row[i] == v)
						pos = i;
				end
				if (pos < 0) begin
					res.status = ST_NOT_FOUND;
				end else begin
					res.found = 1'b1;
					for (i = pos; i + 1 < shadow_count; i++)
						shadow_row[i] = shadow_row[i+1];
					// Removing the entry under the cursor or one after it shortens the walk.
					if (shadow_ahead != 0 && pos >= cur)
						shadow_ahead--;
					shadow_count--;
				end
			end
			FN_LOOKUP: begin
				for (i = 0; i < shadow_count; i++) begin
					if (shadow_row[i] == v)
						res.found = 1'b1;
				end
			end
			FN_REWIND: begin
				shadow_ahead = shadow_count;
			end
			FN_READ: begin
				if (shadow_ahead == 0 || cur >= CAPACITY) begin
					res.status = ST_END;
				end else begin
					res.item = shadow_row[cur];
					shadow_ahead--;
				end
			end
			default: begin
				// Spare codes change nothing and only report the flags.
			end
		endcase
		res.count = CW'(shadow_count);
		res.empty = (shadow_count == 0);
		res.more  = (shadow_ahead != 0);
		return res;
	endfunction

	// Compare result beats first, then queue the prediction for a new input beat.
	always @(posedge clk or negedge arst_n) begin : watch
		table_result_t want;
		logic          bad;
		if (!arst_n) begin
			shadow_count = 0;
			shadow_ahead = 0;
			expected_results.delete();
			fail_cnt    = 0;
			pending_cnt = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("%0t: result beat arrived with nothing expected", $realtime);
				end else begin
					want = expected_results.pop_front();
					bad = (status !== want.status) || (found !== want.found) ||
						(item_out !== want.item) || (entry_count !== want.count) ||
						(is_empty !== want.empty) || (more_to_read !== want.more);
					if (bad) begin
						fail_cnt++;
						if (fail_cnt <= 10) begin
							$write("%0t: mismatch (expected/actual) status %0d/%0d found %0b/%0b ",
								$realtime, want.status, status, want.found, found);
							$display("item %0h/%0h count %0d/%0d empty %0b/%0b more %0b/%0b",
								want.item, item_out, want.count, entry_count,
								want.empty, is_empty, want.more, more_to_read);
						end
					end
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(apply_table_op(func, value));
			pending_cnt = expected_results.size();
		end
	end

endmodule

// ===== verif/sorted_list_table_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_list_table_tb: top level of the sorted list table testbench
// Drives a directed opening of edge cases, then phases of random operations
// that fill, drain and walk the table, with random idling on both channels,
// one long result-side hold-off and one full drain. The checker does the
// prediction; this module makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module sorted_list_table_tb;
	import slt_pkg::*;

	localparam int DW          = DATA_WIDTH_DEF;
	localparam int CW          = $clog2(CAPACITY_DEF + 1);
	localparam int ITEMS       = 1900;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int POOL        = 12;
	// Function codes the block treats as no operation.
	localparam int OP_SPARE_LO = 5;
	localparam int OP_SPARE_HI = 7;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_WALK, MIX_NOISE} mix_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic [2:0]    func;
	logic [DW-1:0] value;
	logic          out_valid;
	logic          out_ready;
	logic [1:0]    status;
	logic          found;
	logic [DW-1:0] item_out;
	logic [CW-1:0] entry_count;
	logic          is_empty;
	logic          more_to_read;

	int            fail_cnt;
	int            pending_cnt;
	int            sent_cnt   = 0;
	int            cycle_cnt  = 0;
	logic [DW-1:0] value_pool [POOL];

	sorted_list_table u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.found        (found),
		.item_out     (item_out),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.more_to_read (more_to_read)
	);

	sorted_list_table_chk u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.found        (found),
		.item_out     (item_out),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.more_to_read (more_to_read),
		.fail_cnt     (fail_cnt),
		.pending_cnt  (pending_cnt)
	);

	always #4 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Offers one input beat and holds it until the block takes it.
	task automatic send_beat(input logic [2:0] op, input logic [DW-1:0] v);
		@(negedge clk);
		in_valid <= 1'b1;
		func     <= op;
		value    <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_cnt++;
	endtask

	// Leaves the input channel empty for a number of cycles.
	task automatic idle_sender(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	// Operation mix per phase: filling, draining, walking the cursor, or noise.
	function automatic logic [2:0] pick_op(input mix_t mix);
		int r;
		int w_ins;
		int w_del;
		int w_look;
		int w_rew;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:  begin w_ins = 60; w_del = 70; w_look = 80; w_rew = 85; end
			MIX_DRAIN: begin w_ins = 15; w_del = 65; w_look = 75; w_rew = 80; end
			MIX_WALK:  begin w_ins = 20; w_del = 40; w_look = 50; w_rew = 58; end
			default:   return 3'($urandom_range(0, 7));
		endcase
		if (r < w_ins)
			return FN_INSERT;
		if (r < w_del)
			return FN_DELETE;
		if (r < w_look)
			return FN_LOOKUP;
		if (r < w_rew)
			return FN_REWIND;
		if (r < 98)
			return FN_READ;
		return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
	endfunction

	// Mostly values from a small pool, so duplicates and hits are common.
	function automatic logic [DW-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return DW'($urandom_range(0, 16'hFFFF));
		if (r < 17)
			return ($urandom_range(0, 1) != 0) ? {DW{1'b1}} : '0;
		return value_pool[$urandom_range(0, POOL - 1)];
	endfunction

	// Result side: random holds, calm stretches and one long hold-off.
	initial begin : receiver
		int  r;
		int  calm_left;
		bit  long_hold_done;
		out_ready      = 1'b0;
		calm_left      = 0;
		long_hold_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && sent_cnt >= 300) begin
				// Hold off long enough for the block to stall its input side.
				out_ready <= 1'b0;
				repeat (400)
					@(negedge clk);
				out_ready      <= 1'b1;
				long_hold_done = 1;
			end else if (calm_left > 0) begin
				calm_left--;
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					calm_left = $urandom_range(20, 80);
					out_ready <= 1'b1;
				end else if (r < 22) begin
					out_ready <= 1'b0;
					repeat ($urandom_range(0, 2))
						@(negedge clk);
				end else if (r < 25) begin
					out_ready <= 1'b0;
					repeat ($urandom_range(15, 50))
						@(negedge clk);
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// Input side: reset, directed opening, random phases, then the verdict.
	initial begin : stimulus
		mix_t mix;
		int   phase_len;
		int   calm_left;
		int   r;
		int   k;
		bit   drained_once;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		func         = FN_INSERT;
		value        = '0;
		calm_left    = 0;
		drained_once = 0;
		for (k = 0; k < POOL; k++)
			value_pool[k] = DW'($urandom_range(0, 16'hFFFF));
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Operations on the empty table, then the spare codes.
		send_beat(FN_READ, 16'h1234);
		send_beat(FN_REWIND, 16'h0000);
		send_beat(FN_DELETE, 16'd5);
		send_beat(FN_LOOKUP, 16'd5);
		for (k = OP_SPARE_LO; k <= OP_SPARE_HI; k++)
			send_beat(3'(k), 16'hFFFF);
		// Extremes and a duplicate.
		send_beat(FN_INSERT, 16'd100);
		send_beat(FN_INSERT, 16'h0000);
		send_beat(FN_INSERT, 16'hFFFF);
		send_beat(FN_INSERT, 16'd100);
		send_beat(FN_INSERT, 16'd50);
		// Park the cursor on the first 100, then insert around it.
		send_beat(FN_REWIND, 16'h0000);
		send_beat(FN_READ, 16'h0000);
		send_beat(FN_READ, 16'h0000);
		send_beat(FN_INSERT, 16'd20);
		send_beat(FN_INSERT, 16'd200);
		send_beat(FN_INSERT, 16'd100);
		// Delete before, after and again before the cursor.
		send_beat(FN_DELETE, 16'd100);
		send_beat(FN_DELETE, 16'd200);
		send_beat(FN_DELETE, 16'h0000);
		send_beat(FN_LOOKUP, 16'hFFFF);
		send_beat(FN_READ, 16'h0000);
		send_beat(FN_READ, 16'h0000);

		// Random phases with a slowly changing value pool.
		while (sent_cnt < ITEMS) begin
			mix       = mix_t'($urandom_range(0, 3));
			phase_len = $urandom_range(40, 120);
			for (k = 0; k < 3; k++)
				value_pool[$urandom_range(0, POOL - 1)] = DW'($urandom_range(0, 16'hFFFF));
			if (mix == MIX_WALK)
				send_beat(FN_REWIND, pick_value());
			repeat (phase_len) begin
				if (!drained_once && sent_cnt >= 1000) begin
					// Let every outstanding result come back before going on.
					idle_sender(1);
					wait (pending_cnt == 0);
					drained_once = 1;
				end
				if (calm_left > 0) begin
					calm_left--;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 4)
						calm_left = $urandom_range(20, 80);
					else if (r < 22)
						idle_sender($urandom_range(1, 3));
					else if (r < 25)
						idle_sender($urandom_range(15, 50));
				end
				send_beat(pick_op(mix), pick_value());
			end
		end

		idle_sender(1);
		wait (pending_cnt == 0);
		repeat (20)
			@(posedge clk);
		if (fail_cnt == 0 && pending_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
